[src/wvfr_pkg.sv]
// package for the wind vector frame rotation block
// types, field widths and fixed-point helpers; no dependencies
package wvfr_pkg;

    localparam int unsigned HealthGood = 3;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_POS  = 2'd3
    } t_reg_idx;

    typedef logic signed [15:0] t_lane;
    typedef logic signed [33:0] t_rmat;   // rotation entry, 28 fraction bits
    typedef logic signed [51:0] t_wide;

    // signed 16-bit lane k of a packed word
    function automatic t_lane lane_of(input logic [63:0] word, input int unsigned k);
        lane_of = t_lane'(word[16*k +: 16]);
    endfunction

    // saturate to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        if (v > 36'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (v < -36'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

endpackage

[src/wvfr_rot.sv]
// rotation matrix stage of the wind vector frame rotation block
// uses wvfr_pkg; two register stages: quaternion products, then matrix entries
module wvfr_rot (
    input  logic                  i_clk,
    input  logic [63:0]           i_quat,
    output wvfr_pkg::t_rmat       o_r [9]
);
    import wvfr_pkg::*;

    t_lane w, x, y, z;
    logic signed [31:0] r_p [10];
    t_rmat r_r [9];

    assign w = lane_of(i_quat, 0);
    assign x = lane_of(i_quat, 1);
    assign y = lane_of(i_quat, 2);
    assign z = lane_of(i_quat, 3);

    // quaternion products
    always_ff @(posedge i_clk) begin
        r_p[0] <= x * x; r_p[1] <= y * y; r_p[2] <= z * z;
        r_p[3] <= x * y; r_p[4] <= x * z; r_p[5] <= y * z;
        r_p[6] <= w * x; r_p[7] <= w * y; r_p[8] <= w * z;
        r_p[9] <= '0;
    end

    // matrix entries, 28 fraction bits
    always_ff @(posedge i_clk) begin
        r_r[0] <= (t_rmat'(1) <<< 28) - ((t_rmat'(r_p[1]) + t_rmat'(r_p[2])) <<< 1);
        r_r[1] <= (t_rmat'(r_p[3]) - t_rmat'(r_p[8])) <<< 1;
        r_r[2] <= (t_rmat'(r_p[4]) + t_rmat'(r_p[7])) <<< 1;
        r_r[3] <= (t_rmat'(r_p[3]) + t_rmat'(r_p[8])) <<< 1;
        r_r[4] <= (t_rmat'(1) <<< 28) - ((t_rmat'(r_p[0]) + t_rmat'(r_p[2])) <<< 1);
        r_r[5] <= (t_rmat'(r_p[5]) - t_rmat'(r_p[6])) <<< 1;
        r_r[6] <= (t_rmat'(r_p[4]) - t_rmat'(r_p[7])) <<< 1;
        r_r[7] <= (t_rmat'(r_p[5]) + t_rmat'(r_p[6])) <<< 1;
        r_r[8] <= (t_rmat'(1) <<< 28) - ((t_rmat'(r_p[0]) + t_rmat'(r_p[1])) <<< 1)
                  + t_rmat'(r_p[9]);
    end

    assign o_r = r_r;
endmodule

[src/wind_vector_frame_rotation.sv]
// top level of the wind vector frame rotation block
// uses wvfr_pkg and wvfr_rot
// Takes one item per cycle whenever start is high; busy stays low. Each item
// leaves the five-stage pipeline through its last stage, on o_done for
// one cycle; the receiver cannot hold results off. Depth is set by the chain
// quaternion products, matrix entries, body-frame products, bracket rounding,
// final rotation products.
module wind_vector_frame_rotation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic [63:0] i_attitude_quat,
    input  logic [47:0] i_air_rel_vel,
    input  logic [47:0] i_inertial_vel,
    input  logic [47:0] i_body_rate,
    input  logic [7:0]  i_gps_health,
    output logic        o_done,
    output logic signed [15:0] o_wind_east,
    output logic signed [15:0] o_wind_north,
    output logic signed [15:0] o_wind_up,
    output logic        o_improved_mode
);
    import wvfr_pkg::*;

    logic [47:0] r_m [3];
    logic [47:0] r_pos;
    logic [4:0]  r_vld;
    logic [4:0]  r_imp;
    t_rmat       rot [9];

    // stage 1/2 payload
    logic signed [32:0] r_mv1 [3];
    logic signed [32:0] r_cr1 [3];
    t_lane r_lin1 [3], r_lin2 [3];
    logic signed [32:0] r_mv2 [3];
    logic signed [32:0] r_cr2 [3];
    // stage 3
    t_wide r_br3 [3];
    t_rmat r_rot3 [9];
    // stage 4
    logic signed [27:0] r_vec4 [3];
    t_rmat r_rot4 [9];
    // stage 5
    logic signed [15:0] r_out [3];

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[0] <= 48'd16384;
            r_m[1] <= 48'd1073741824;
            r_m[2] <= 48'd70368744177664;
            r_pos  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW0: r_m[0] <= i_cfg_data;
                REG_ROW1: r_m[1] <= i_cfg_data;
                REG_ROW2: r_m[2] <= i_cfg_data;
                REG_POS:  r_pos  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid and mode bits travel with the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], start};
        end
        r_imp <= {r_imp[3:0], (i_gps_health >= 8'(HealthGood))};
    end

    wvfr_rot u_rot (.i_clk(i_clk), .i_quat(i_attitude_quat), .o_r(rot));

    // stage 1: mount products and cross product, 22 fraction bits
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mv1[i] <= 33'(lane_of({16'd0, r_m[i]}, 0) * lane_of({16'd0, i_air_rel_vel}, 0))
                      + 33'(lane_of({16'd0, r_m[i]}, 1) * lane_of({16'd0, i_air_rel_vel}, 1))
                      + 33'(lane_of({16'd0, r_m[i]}, 2) * lane_of({16'd0, i_air_rel_vel}, 2));
            r_lin1[i] <= lane_of({16'd0, i_inertial_vel}, i);
        end
        r_cr1[0] <= 33'(lane_of({16'd0, i_body_rate}, 1) * lane_of({16'd0, r_pos}, 2))
                  - 33'(lane_of({16'd0, i_body_rate}, 2) * lane_of({16'd0, r_pos}, 1));
        r_cr1[1] <= 33'(lane_of({16'd0, i_body_rate}, 2) * lane_of({16'd0, r_pos}, 0))
                  - 33'(lane_of({16'd0, i_body_rate}, 0) * lane_of({16'd0, r_pos}, 2));
        r_cr1[2] <= 33'(lane_of({16'd0, i_body_rate}, 0) * lane_of({16'd0, r_pos}, 1))
                  - 33'(lane_of({16'd0, i_body_rate}, 1) * lane_of({16'd0, r_pos}, 0));
    end

    // stage 2: hold alongside matrix entries
    always_ff @(posedge i_clk) begin
        r_mv2  <= r_mv1;
        r_cr2  <= r_cr1;
        r_lin2 <= r_lin1;
    end

    // stage 3: bracket sum, 36 fraction bits
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_imp[1]) begin
                r_br3[i] <= 52'(rot[i] * r_lin2[0]) + 52'(rot[3+i] * r_lin2[1])
                          + 52'(rot[6+i] * r_lin2[2])
                          + ((52'(r_cr2[i]) - 52'(r_mv2[i])) <<< 14);
            end else begin
                r_br3[i] <= 52'(r_mv2[i]) <<< 14;
            end
        end
        r_rot3 <= rot;
    end

    // stage 4: round bracket to 14 fraction bits
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_vec4[i] <= 28'((r_br3[i] + (52'sd1 <<< 21)) >>> 22);
        end
        r_rot4 <= r_rot3;
    end

    // stage 5: final rotation, round to 8 fraction bits and saturate
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_out[i] <= sat16(36'(((64'(r_rot4[3*i] * r_vec4[0])
                          + 64'(r_rot4[3*i+1] * r_vec4[1])
                          + 64'(r_rot4[3*i+2] * r_vec4[2]))
                          + (64'sd1 <<< 33)) >>> 34));
        end
    end

    assign o_done          = r_vld[4];
    assign o_wind_east     = r_out[0];
    assign o_wind_north    = r_out[1];
    assign o_wind_up       = r_out[2];
    assign o_improved_mode = r_imp[4];
endmodule
